FILE: src/srb_pkg.sv
// Shared action codes, status codes and default sizes of the sequence reorder buffer.
`default_nettype none

package srb_pkg;

	// Default window depth and handle width.
	localparam int DEF_WINDOW_DEPTH = 16;
	localparam int DEF_HANDLE_BITS  = 16;

	// Widths of the fixed fields.
	localparam int SEQ_W    = 32;
	localparam int ACTION_W = 3;
	localparam int STATUS_W = 2;

	// Action codes.
	localparam logic [ACTION_W-1:0] ACT_PARK    = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_ADV_REL = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_OFFER   = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_ADVANCE = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd5;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUP    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

endpackage

`default_nettype wire

FILE: src/sequence_reorder_buffer.sv
// Top level of the sequence reorder buffer: window storage, expected number and result register.
`default_nettype none

// The block takes one action per transfer and returns exactly one result per action, in
// order. It keeps the sequence number it expects next and a window of WINDOW_DEPTH slots;
// an entry lives in slot (sequence mod WINDOW_DEPTH). A new item can be accepted on every
// cycle unless a stalled output holds stage 1; its result goes via stage 1 into an output
// register that lets the next item be accepted while the result waits to be taken. The rate is
// set by the window memory, which is read with registered data at the input transfer and written
// once per item when an entry is parked; a park in the preceding item is forwarded around it.
// Slot valid bits sit in flip-flops and are cleared by reset; parked entries survive the
// reset action, which only returns the expected number to zero.
module sequence_reorder_buffer
	import srb_pkg::*;
#(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
	parameter int HANDLE_BITS  = DEF_HANDLE_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Input channel
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [ACTION_W-1:0]    action,
	input  wire logic [SEQ_W-1:0]       seq_number,
	input  wire logic [HANDLE_BITS-1:0] buffer_handle,
	// Output channel
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [STATUS_W-1:0]         status,
	output logic                        release_valid,
	output logic [HANDLE_BITS-1:0]      release_handle,
	output logic                        list_empty,
	output logic [SEQ_W-1:0]            expected_seq
);

	localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam logic [SEQ_W-1:0] DEPTH_SEQ = SEQ_W'(WINDOW_DEPTH);
	localparam logic [IDX_W:0]   DEPTH_X   = (IDX_W + 1)'(WINDOW_DEPTH);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WINDOW_DEPTH - 1);

	// Expected number and its slot index, tracked at input transfer time.
	logic [SEQ_W-1:0] ne_q;
	logic [IDX_W-1:0] nm_q;
	logic [SEQ_W-1:0] ne_nx;
	logic [IDX_W-1:0] nm_nx;

	// Stage 1 registers.
	logic                   valid_s1;
	logic [ACTION_W-1:0]    action_s1;
	logic [SEQ_W-1:0]       seq_s1;
	logic [HANDLE_BITS-1:0] handle_s1;
	logic [SEQ_W-1:0]       ne_s1;
	logic [IDX_W-1:0]       p_idx_s1;
	logic [IDX_W-1:0]       r_idx_s1;
	logic                   win_s1;
	logic                   byp_p_s1;
	logic                   byp_r_s1;
	logic [SEQ_W-1:0]       byp_seq_s1;
	logic [HANDLE_BITS-1:0] byp_handle_s1;
	logic [SEQ_W-1:0]       mem_pseq_s1;
	logic [SEQ_W-1:0]       mem_rseq_s1;
	logic [HANDLE_BITS-1:0] mem_rhandle_s1;

	// Window storage.
	logic [WINDOW_DEPTH-1:0] slot_valid_q;
	logic [SEQ_W-1:0]        seq_mem [WINDOW_DEPTH];
	logic [HANDLE_BITS-1:0]  hdl_mem [WINDOW_DEPTH];
	logic [CNT_W-1:0]        cnt_q;

	// Output register.
	logic                   out_valid_q;
	logic [STATUS_W-1:0]    status_q;
	logic                   rel_valid_q;
	logic [HANDLE_BITS-1:0] rel_handle_q;
	logic                   empty_q;
	logic [SEQ_W-1:0]       expected_q;

	logic accept;
	logic out_free;
	logic s1_adv;

	// Handshake: stage 1 moves on when the output register is free or being emptied.
	assign out_free = !out_valid_q || !out_stall;
	assign s1_adv   = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	// Park slot: inside the window the offset from the expected number is below the depth,
	// so one compare and subtract on the expected slot index gives the slot.
	logic [SEQ_W-1:0] in_diff;
	logic             in_win;
	logic [IDX_W:0]   p_sum;
	logic [IDX_W-1:0] p_addr_in;

	assign in_diff   = seq_number - ne_q;
	assign in_win    = in_diff < DEPTH_SEQ;
	assign p_sum     = {1'b0, nm_q} + {1'b0, in_diff[IDX_W-1:0]};
	assign p_addr_in = (p_sum >= DEPTH_X) ? IDX_W'(p_sum - DEPTH_X) : p_sum[IDX_W-1:0];

	// Expected number after this action; the slot index follows it, including the 2^32 wrap.
	always_comb begin
		ne_nx = ne_q;
		nm_nx = nm_q;
		case (action)
			ACT_ADV_REL, ACT_ADVANCE: begin
				ne_nx = ne_q + SEQ_W'(1);
				nm_nx = (ne_q == '1 || nm_q == LAST_IDX) ? '0 : nm_q + IDX_W'(1);
			end
			ACT_CLEAR: begin
				ne_nx = '0;
				nm_nx = '0;
			end
			default: begin
				ne_nx = ne_q;
				nm_nx = nm_q;
			end
		endcase
	end

	// Stage 1 decisions.
	logic                   eq_ne;
	logic                   do_park;
	logic                   do_rel;
	logic                   pass;
	logic [SEQ_W-1:0]       p_seq;
	logic [SEQ_W-1:0]       r_seq;
	logic [HANDLE_BITS-1:0] r_handle;
	logic                   p_valid;
	logic                   r_valid;
	logic [STATUS_W-1:0]    park_st;
	logic                   park_wr;
	logic                   rel_hit;
	logic [STATUS_W-1:0]    st_nx;
	logic                   rel_nx;
	logic [HANDLE_BITS-1:0] rel_handle_nx;
	logic [CNT_W-1:0]       cnt_nx;
	logic                   wr_en;

	assign eq_ne    = seq_s1 == ne_s1;
	assign do_park  = (action_s1 == ACT_PARK) || (action_s1 == ACT_OFFER && !eq_ne);
	assign do_rel   = (action_s1 == ACT_ADV_REL) || (action_s1 == ACT_RELEASE)
		|| (action_s1 == ACT_OFFER && !eq_ne);
	assign pass     = (action_s1 == ACT_OFFER) && eq_ne;
	assign p_seq    = byp_p_s1 ? byp_seq_s1 : mem_pseq_s1;
	assign r_seq    = byp_r_s1 ? byp_seq_s1 : mem_rseq_s1;
	assign r_handle = byp_r_s1 ? byp_handle_s1 : mem_rhandle_s1;
	assign p_valid  = slot_valid_q[p_idx_s1];
	assign r_valid  = slot_valid_q[r_idx_s1];

	// Park outcome: outside the window or a foreign entry rejects, the same entry is a duplicate.
	always_comb begin
		park_st = ST_OK;
		park_wr = 1'b0;
		if (!win_s1) begin
			park_st = ST_REJECT;
		end else if (p_valid) begin
			park_st = (p_seq == seq_s1) ? ST_DUP : ST_REJECT;
		end else begin
			park_wr = do_park;
		end
	end

	assign st_nx         = do_park ? park_st : ST_OK;
	assign rel_hit       = do_rel && r_valid && (r_seq == ne_s1);
	assign rel_nx        = rel_hit || pass;
	assign rel_handle_nx = pass ? handle_s1 : (rel_hit ? r_handle : '0);
	assign cnt_nx        = cnt_q + CNT_W'(park_wr) - CNT_W'(rel_hit);
	assign wr_en         = s1_adv && park_wr;

	// Expected number tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ne_q <= '0;
			nm_q <= '0;
		end else if (accept) begin
			ne_q <= ne_nx;
			nm_q <= nm_nx;
		end
	end

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload, with forwarding of a park committed on the same edge.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1     <= action;
			seq_s1        <= seq_number;
			handle_s1     <= buffer_handle;
			ne_s1         <= ne_nx;
			p_idx_s1      <= p_addr_in;
			r_idx_s1      <= nm_nx;
			win_s1        <= in_win;
			byp_p_s1      <= wr_en && (p_idx_s1 == p_addr_in);
			byp_r_s1      <= wr_en && (p_idx_s1 == nm_nx);
			byp_seq_s1    <= seq_s1;
			byp_handle_s1 <= handle_s1;
		end
	end

	// Window memory: one write port for parks, registered reads at the input transfer.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			seq_mem[p_idx_s1] <= seq_s1;
			hdl_mem[p_idx_s1] <= handle_s1;
		end
		if (accept) begin
			mem_pseq_s1    <= seq_mem[p_addr_in];
			mem_rseq_s1    <= seq_mem[nm_nx];
			mem_rhandle_s1 <= hdl_mem[nm_nx];
		end
	end

	// Slot valid bits and parked entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			cnt_q        <= '0;
		end else if (s1_adv) begin
			if (park_wr) begin
				slot_valid_q[p_idx_s1] <= 1'b1;
			end
			if (rel_hit) begin
				slot_valid_q[r_idx_s1] <= 1'b0;
			end
			cnt_q <= cnt_nx;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (s1_adv) begin
			status_q     <= st_nx;
			rel_valid_q  <= rel_nx;
			rel_handle_q <= rel_handle_nx;
			empty_q      <= cnt_nx == '0;
			expected_q   <= ne_s1;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign release_valid  = rel_valid_q;
	assign release_handle = rel_handle_q;
	assign list_empty     = empty_q;
	assign expected_seq   = expected_q;

endmodule

`default_nettype wire
